// ===== hdl/sosc_pkg.sv =====
`default_nettype none

package sosc_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_N           = 1 << (SINE_TABLE_BITS - 2);
  localparam int ADDR_W          = SINE_TABLE_BITS - 1;

  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 16;
  localparam int ACC_W       = 48;
  localparam int ALU_W       = ACC_W + 1;
  localparam int RAMP_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int ENTRY_W     = SAMPLE_W - 1;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int MAG_W       = PROD_W - 1;
  localparam int PROD_FRAC   = 15;
  localparam int ROUND_W     = MAG_W - PROD_FRAC + 1;
  localparam int DIV_CNT_W   = $clog2(ACC_W);
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEPS = CFG_INDEX_W'(1);

  localparam logic [RAMP_W-1:0]  RAMP_STEPS_RESET = RAMP_W'(480);
  localparam logic [ALU_W-1:0]   ROUND_HALF       = ALU_W'(1 << (PROD_FRAC - 1));
  localparam logic [ROUND_W-1:0] POS_LIMIT        = ROUND_W'(32767);
  localparam logic [ROUND_W-1:0] NEG_LIMIT        = ROUND_W'(32768);
  localparam logic [SAMPLE_W-1:0] SAT_POS         = SAMPLE_W'(16'h7fff);
  localparam logic [SAMPLE_W-1:0] SAT_NEG         = SAMPLE_W'(16'h8000);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GOAL,
    S_DIFF,
    S_ABS,
    S_DIV,
    S_NEG,
    S_PHASE,
    S_RAMP,
    S_MUL,
    S_MAG,
    S_RND,
    S_STEP,
    S_OUT
  } state_t;

  typedef logic [ENTRY_W-1:0] qtab_t [0:QTR_N];

  function automatic logic [ENTRY_W-1:0] quarter_entry(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (HALF_PI_Q30 * k) >> (SINE_TABLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[ENTRY_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QTR_N; k++) begin
      t[k] = quarter_entry(64'(k));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

// ===== hdl/sosc_alu.sv =====
`default_nettype none

module sosc_alu
  import sosc_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  input  wire alu_op_t          op,
  output logic      [ALU_W-1:0] y
);

  always_comb begin
    case (op)
      ALU_SUB: y = a - b;
      ALU_ADD: y = a + b;
      default: y = a + b;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sosc_rom.sv =====
`default_nettype none

module sosc_rom
  import sosc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic [SINE_TABLE_BITS-1:0] idx,
  output logic signed [SAMPLE_W-1:0]      sine
);

  localparam logic [ADDR_W-1:0] QTR_TOP = ADDR_W'(QTR_N);

  logic [ADDR_W-2:0]   j;
  logic [ADDR_W-1:0]   addr;
  logic [ENTRY_W-1:0]  rom_q;
  logic                neg_q;
  logic [SAMPLE_W-1:0] mag16;

  assign j    = idx[SINE_TABLE_BITS-3:0];
  assign addr = idx[SINE_TABLE_BITS-2] ? (QTR_TOP - {1'b0, j}) : {1'b0, j};

  always_ff @(posedge clk) begin
    rom_q <= QTAB[addr];
    neg_q <= idx[SINE_TABLE_BITS-1];
  end

  assign mag16 = {1'b0, rom_q};
  assign sine  = neg_q ? (~mag16 + 1'b1) : mag16;

endmodule

`default_nettype wire

// ===== hdl/sine_oscillator_fm_gain_ramp_top.sv =====
// Each word runs through GOAL, PHASE, RAMP, MUL, MAG, RND, STEP and OUT; when the target
// gain changes with ramp_steps nonzero, DIFF, ABS, a bit-serial ramp division (DIV) and
// NEG come after GOAL. A new word is taken only after OUT has passed the last one on to a
// free output slot; one shared 49-bit adder carries the phase, gain, rounding and division
// arithmetic in turn. Reset: synchronous; phase, gain and ramp state clear, phase_step
// clears, ramp_steps returns to 480, and the block is ready for a word in the first cycle after reset.
`default_nettype none

module sine_oscillator_fm_gain_ramp_top
  import sosc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [PHASE_W-1:0]   fm_offset,
  input  wire logic        [GAIN_W-1:0]    target_gain,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed      [SAMPLE_W-1:0]  sample,
  output logic                             ramp_active,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);

  state_t state;
  state_t state_next;

  logic [PHASE_W-1:0] phase_step;
  logic [RAMP_W-1:0]  ramp_steps;
  logic [PHASE_W-1:0] phase;
  logic [ACC_W-1:0]   gain_now;
  logic [GAIN_W-1:0]  gain_goal;
  logic [ACC_W-1:0]   gain_inc;
  logic [RAMP_W-1:0]  ramp_left;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [PHASE_W-1:0]  fm;
  logic [GAIN_W-1:0]   tg;
  logic [ALU_W-1:0]    diff;
  logic [ACC_W-1:0]    dvd;
  logic [RAMP_W-1:0]   rem;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]    mag;
  logic                prod_neg;
  logic [SAMPLE_W-1:0] res;
  logic [SAMPLE_W-1:0] res_next;
  logic [ROUND_W-1:0]  rounded;

  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_y;
  alu_op_t          alu_op;

  logic signed [SAMPLE_W-1:0] sine;
  logic                       slot_free;
  logic [ACC_W-1:0]           goal_full;
  logic [ACC_W-1:0]           tg_full;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign slot_free = !out_valid || out_ready;
  assign goal_full = {gain_goal, {(ACC_W - GAIN_W){1'b0}}};
  assign tg_full   = {tg, {(ACC_W - GAIN_W){1'b0}}};

  sosc_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  sosc_rom u_rom (
    .clk  (clk),
    .idx  (idx),
    .sine (sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = ALU_ADD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_GOAL;
        end
      end
      S_GOAL: begin
        if (tg != gain_goal && ramp_steps != '0) begin
          state_next = S_DIFF;
        end else begin
          state_next = S_PHASE;
        end
      end
      S_DIFF: begin
        alu_a      = {1'b0, tg_full};
        alu_b      = {1'b0, gain_now};
        alu_op     = ALU_SUB;
        state_next = S_ABS;
      end
      S_ABS: begin
        if (diff[ALU_W-1]) begin
          alu_b  = diff;
          alu_op = ALU_SUB;
        end else begin
          alu_a = diff;
        end
        state_next = S_DIV;
      end
      S_DIV: begin
        alu_a  = {{(ALU_W - RAMP_W - 1){1'b0}}, rem, dvd[ACC_W-1]};
        alu_b  = {{(ALU_W - RAMP_W){1'b0}}, ramp_steps};
        alu_op = ALU_SUB;
        if (div_cnt == DIV_LAST) begin
          state_next = S_NEG;
        end
      end
      S_NEG: begin
        if (diff[ALU_W-1]) begin
          alu_b  = {1'b0, dvd};
          alu_op = ALU_SUB;
        end else begin
          alu_a = {1'b0, dvd};
        end
        state_next = S_PHASE;
      end
      S_PHASE: begin
        alu_a      = {{(ALU_W - PHASE_W){1'b0}}, phase};
        alu_b      = {{(ALU_W - PHASE_W){1'b0}}, fm};
        state_next = S_RAMP;
      end
      S_RAMP: begin
        alu_a      = {1'b0, gain_now};
        alu_b      = {1'b0, gain_inc};
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_MAG;
      end
      S_MAG: begin
        if (prod[PROD_W-1]) begin
          alu_b  = {{(ALU_W - PROD_W){prod[PROD_W-1]}}, prod};
          alu_op = ALU_SUB;
        end else begin
          alu_a = {{(ALU_W - PROD_W){1'b0}}, prod};
        end
        state_next = S_RND;
      end
      S_RND: begin
        alu_a      = {{(ALU_W - MAG_W){1'b0}}, mag};
        alu_b      = ROUND_HALF;
        state_next = S_STEP;
      end
      S_STEP: begin
        alu_a      = {{(ALU_W - PHASE_W){1'b0}}, phase};
        alu_b      = {{(ALU_W - PHASE_W){1'b0}}, phase_step};
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // round half away from zero, then saturate
  always_comb begin
    rounded = alu_y[PROD_FRAC +: ROUND_W];
    if (!prod_neg) begin
      res_next = (rounded > POS_LIMIT) ? SAT_POS : rounded[SAMPLE_W-1:0];
    end else begin
      res_next = (rounded > NEG_LIMIT) ? SAT_NEG : (~rounded[SAMPLE_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      ramp_steps <= RAMP_STEPS_RESET;
      phase      <= '0;
      gain_now   <= '0;
      gain_goal  <= '0;
      gain_inc   <= '0;
      ramp_left  <= '0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_GOAL: begin
          if (tg != gain_goal) begin
            gain_goal <= tg;
            if (ramp_steps == '0) begin
              gain_now  <= tg_full;
              ramp_left <= '0;
              gain_inc  <= '0;
            end else begin
              ramp_left <= ramp_steps;
            end
          end
        end
        S_ABS: begin
          div_cnt <= '0;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
        end
        S_NEG: begin
          gain_inc <= alu_y[ACC_W-1:0];
        end
        S_RAMP: begin
          if (ramp_left != '0) begin
            ramp_left <= ramp_left - 1'b1;
            if (ramp_left == RAMP_W'(1)) begin
              gain_now <= goal_full;
            end else begin
              gain_now <= alu_y[ACC_W-1:0];
            end
          end
        end
        S_STEP: begin
          phase <= alu_y[PHASE_W-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP: begin
            phase_step <= cfg_data[PHASE_W-1:0];
          end
          REG_RAMP_STEPS: begin
            ramp_steps <= cfg_data[RAMP_W-1:0];
            gain_now   <= goal_full;
            ramp_left  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fm <= fm_offset;
          tg <= target_gain;
        end
      end
      S_DIFF: begin
        diff <= alu_y;
      end
      S_ABS: begin
        dvd <= alu_y[ACC_W-1:0];
        rem <= '0;
      end
      S_DIV: begin
        if (!alu_y[ALU_W-1]) begin
          rem <= alu_y[RAMP_W-1:0];
        end else begin
          rem <= {rem[RAMP_W-2:0], dvd[ACC_W-1]};
        end
        dvd <= {dvd[ACC_W-2:0], !alu_y[ALU_W-1]};
      end
      S_PHASE: begin
        idx <= alu_y[PHASE_W-1 -: SINE_TABLE_BITS];
      end
      S_MUL: begin
        prod <= sine * $signed({1'b0, gain_now[ACC_W-1 -: GAIN_W]});
      end
      S_MAG: begin
        mag      <= alu_y[MAG_W-1:0];
        prod_neg <= prod[PROD_W-1];
      end
      S_RND: begin
        res <= res_next;
      end
      S_OUT: begin
        if (slot_free) begin
          sample      <= res;
          ramp_active <= (ramp_left != '0);
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt <= DIV_LAST)
    else $error("division step count out of range");

  assert property (@(posedge clk) disable iff (rst)
    ramp_left <= ramp_steps)
    else $error("ramp length exceeds ramp_steps");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RAMP && ramp_left == RAMP_W'(1)) |=> gain_now == goal_full)
    else $error("ramp end did not land on the gain goal");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && slot_free) |=> out_valid && ramp_active == (ramp_left != '0))
    else $error("output word not loaded with ramp status");

endmodule

`default_nettype wire

// ===== tb/tb_sine_oscillator_fm_gain_ramp_top.sv =====
`timescale 1ns / 1ps

module tb_sine_oscillator_fm_gain_ramp_top;
  import sosc_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam longint unsigned HALF_PI_Q2_30 = 64'd1686629713;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_HI = CFG_INDEX_W'(3);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] level;
    logic                       ramping;
  } tone_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [PHASE_W-1:0]     fm_offset = '0;
  logic        [GAIN_W-1:0]      target_gain = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample;
  logic                          ramp_active;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic        [CFG_INDEX_W-1:0] cfg_index = '0;
  logic        [CFG_DATA_W-1:0]  cfg_data = '0;

  // oscillator state as predicted
  logic        [31:0]            osc_phase;
  logic        [31:0]            osc_step;
  logic        [15:0]            osc_ramp_len;
  logic        [47:0]            osc_gain;
  logic        [15:0]            osc_goal;
  longint                        osc_inc;
  logic        [15:0]            osc_left;
  logic signed [15:0]            wave_tab [0:QUARTER];

  tone_t  tones_due [$];
  tone_t  tone_seen;
  int     errors = 0;
  int     quiet = 0;
  int     samples_sent = 0;
  int     reg_writes = 0;
  int     ramps_started = 0;
  int     ramps_finished = 0;
  int     burst_left = 0;
  int     rx_left = 0;
  bit     rx_open = 1'b0;
  bit     rx_steady = 1'b0;
  bit     tx_steady = 1'b0;
  bit     in_held = 1'b0;
  bit     cfg_held = 1'b0;

  sine_oscillator_fm_gain_ramp_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .fm_offset   (fm_offset),
    .target_gain (target_gain),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample),
    .ramp_active (ramp_active),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] quarter_wave(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (HALF_PI_Q2_30 * k) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 32767 + 536870912) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sine_of(input logic [31:0] p);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    int unsigned                j;
    logic signed [15:0]         v;
    idx  = p[31 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    j    = idx[SINE_TABLE_BITS-3:0];
    v    = quad[0] ? wave_tab[QUARTER - j] : wave_tab[j];
    return quad[1] ? -v : v;
  endfunction

  function automatic tone_t next_tone(input logic [31:0] fm, input logic [15:0] tg);
    tone_t              r;
    longint             diff;
    longint             prod;
    longint             mag;
    logic signed [15:0] s;
    if (tg != osc_goal) begin
      osc_goal = tg;
      if (osc_ramp_len == 0) begin
        osc_gain = {tg, 32'd0};
        osc_left = '0;
        osc_inc  = 0;
      end else begin
        diff = longint'({16'd0, tg, 32'd0}) - longint'({16'd0, osc_gain});
        osc_inc  = diff / longint'({48'd0, osc_ramp_len});
        osc_left = osc_ramp_len;
        ramps_started++;
      end
    end
    s = sine_of(osc_phase + fm);
    if (osc_left != 0) begin
      osc_left--;
      if (osc_left == 0) begin
        osc_gain = {osc_goal, 32'd0};
        ramps_finished++;
      end else begin
        osc_gain = 48'(longint'({16'd0, osc_gain}) + osc_inc);
      end
    end
    prod = longint'(s) * longint'({48'd0, osc_gain[47:32]});
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + 16384) >>> 15;
    if (prod < 0) begin
      mag = -mag;
    end
    if (mag > 32767) begin
      mag = 32767;
    end
    if (mag < -32768) begin
      mag = -32768;
    end
    osc_phase = osc_phase + osc_step;
    r.level   = mag[15:0];
    r.ramping = (osc_left != 0);
    return r;
  endfunction

  task automatic reset_oscillator();
    for (int k = 0; k <= QUARTER; k++) begin
      wave_tab[k] = quarter_wave(k);
    end
    osc_phase    = '0;
    osc_step     = '0;
    osc_ramp_len = 16'd480;
    osc_gain     = '0;
    osc_goal     = '0;
    osc_inc      = 0;
    osc_left     = '0;
  endtask

  task automatic report(input string what, input longint want, input longint got);
    if (errors < 40) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    end
    errors++;
  endtask

  task automatic release_cfg();
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
  endtask

  task automatic send_word(input logic [31:0] fm, input logic [15:0] tg);
    release_cfg();
    in_valid    <= 1'b1;
    fm_offset   <= fm;
    target_gain <= tg;
    in_held = 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tones_due.push_back(next_tone(fm, tg));
    samples_sent++;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        in_held = 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        burst_left = $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold off until every word owed has come back
  task automatic drain();
    release_cfg();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
    while (tones_due.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_held = 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    reg_writes++;
    case (idx)
      REG_PHASE_STEP: osc_step = data;
      REG_RAMP_STEPS: begin
        osc_ramp_len = data[15:0];
        osc_gain     = {osc_goal, 32'd0};
        osc_left     = '0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_word(32'd0, 16'h0000);
    send_word(32'h4000_0000, 16'h1234);
    drain();
    write_reg(REG_RAMP_STEPS, 32'd0);
    send_word(32'h4000_0000, 16'hFFFF);
    send_word(32'hC000_0000, 16'hFFFF);
    send_word(32'h7FFF_FFFF, 16'hFFFF);
    send_word(32'h8000_0000, 16'hFFFF);
    send_word(32'hFFFF_FFFF, 16'hFFFF);
    send_word(32'h2000_0000, 16'h8000);
    send_word(32'h4000_0000, 16'h8000);
    drain();
    write_reg(REG_PHASE_STEP, 32'h0040_0000);
    write_reg(REG_RAMP_STEPS, 32'd4);
    send_word(32'h1000_0000, 16'h4000);
    send_word(32'd0, 16'h4000);
    send_word(32'd0, 16'h7000);
    repeat (4) send_word(32'd0, 16'h7000);
    send_word(32'd0, 16'hFFFF);
    drain();
    write_reg(REG_RAMP_STEPS, 32'd1);
    send_word(32'd0, 16'hFFFF);
    send_word(32'h4000_0000, 16'h0000);
    drain();
    write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
    write_reg(REG_NONE_HI, 32'hFFFF_FFFF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    send_word(32'h4000_0000, 16'h0000);
    send_word(32'h4000_0000, 16'h0000);
    send_word(32'h8000_0000, 16'h0001);
  endtask

  task automatic test_gain_ramps();
    logic [15:0] ramp_list [0:7];
    logic [15:0] gain;
    int          odds;
    ramp_list = '{16'd0, 16'd1, 16'd2, 16'd7, 16'd16, 16'hFFFF, 16'd0, 16'd0};
    ramp_list[6] = 16'($urandom_range(3, 40));
    ramp_list[7] = 16'($urandom_range(3, 40));
    gain = osc_goal;
    for (int p = 0; p < 8; p++) begin
      drain();
      if (p == 3) begin
        write_reg(REG_NONE_LO, $urandom());
      end
      write_reg(REG_RAMP_STEPS, {16'($urandom()), ramp_list[p]});
      write_reg(REG_PHASE_STEP, $urandom_range(0, 32'h0200_0000));
      odds = (ramp_list[p] > 2) ? 30 : 4;
      rx_steady = (p == 1);
      tx_steady = (p == 1);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, odds) == 0) begin
          gain = pick_gain();
        end
        if ($urandom_range(0, 99) == 0) begin
          drain();
          if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_RAMP_STEPS, {16'($urandom()), ramp_list[p]});
          end
        end
        send_word(pick_offset(), gain);
      end
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  task automatic test_fm_sweep();
    logic [31:0] step_list [0:5];
    logic [15:0] gain;
    step_list = '{32'd0, 32'hFFFF_FFFF, 32'h0040_0000, 32'h8000_0000, 32'd0, 32'd0};
    step_list[4] = $urandom();
    step_list[5] = $urandom();
    gain = osc_goal;
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(REG_PHASE_STEP, step_list[p]);
      write_reg(REG_RAMP_STEPS, {16'($urandom()), 16'($urandom_range(0, 8))});
      if (p == 5) begin
        write_reg(REG_NONE_HI, $urandom());
      end
      rx_steady = (p == 2) || (p == 4);
      tx_steady = (p == 2);
      for (int i = 0; i < 160; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          gain = pick_gain();
        end
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
        send_word(pick_offset(), gain);
      end
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_open = !rx_open;
      if (rx_open) begin
        rx_left = $urandom_range(1, 24);
      end else if ($urandom_range(0, 7) == 0) begin
        rx_left = $urandom_range(20, 40);
      end else begin
        rx_left = $urandom_range(1, 6);
      end
    end else begin
      rx_left--;
    end
    out_ready <= rx_steady || rx_open;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tones_due.size() == 0) begin
          report("unexpected sample", 0, sample);
        end else begin
          tone_seen = tones_due.pop_front();
          if (sample !== tone_seen.level) begin
            report("sample", tone_seen.level, sample);
          end
          if (ramp_active !== tone_seen.ramping) begin
            report("ramp_active", tone_seen.ramping, ramp_active);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d samples outstanding",
                 quiet, tones_due.size());
        $display("tb_sine_oscillator_fm_gain_ramp_top: errors");
        $finish;
      end
    end
  end

  initial begin
    reset_oscillator();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_gain_ramps();
    test_fm_sweep();
    drain();
    repeat (64) @(posedge clk);
    $display("run covered %0d samples across %0d register writes,", samples_sent, reg_writes);
    $display("with %0d gain ramps started and %0d run to the end", ramps_started,
             ramps_finished);
    if (errors == 0) begin
      $display("tb_sine_oscillator_fm_gain_ramp_top: clean");
    end else begin
      $display("tb_sine_oscillator_fm_gain_ramp_top: errors");
    end
    $finish;
  end

endmodule
